// ===== src/rast_pkg.sv =====
// Package: number format, payload structs for the ray/box slab test.
package rast_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] origin_x;
        logic signed [VALUE_WIDTH-1:0] origin_y;
        logic signed [VALUE_WIDTH-1:0] origin_z;
        logic signed [VALUE_WIDTH-1:0] dir_x;
        logic signed [VALUE_WIDTH-1:0] dir_y;
        logic signed [VALUE_WIDTH-1:0] dir_z;
        logic signed [VALUE_WIDTH-1:0] box_lo_x;
        logic signed [VALUE_WIDTH-1:0] box_lo_y;
        logic signed [VALUE_WIDTH-1:0] box_lo_z;
        logic signed [VALUE_WIDTH-1:0] box_hi_x;
        logic signed [VALUE_WIDTH-1:0] box_hi_y;
        logic signed [VALUE_WIDTH-1:0] box_hi_z;
    } t_ray_in;

    typedef struct packed {
        logic                          hit;
        logic signed [VALUE_WIDTH-1:0] t_entry;
    } t_ray_out;

endpackage

// ===== src/ray_aabb_slab_test.sv =====
// Ray versus axis-aligned box slab test, fully pipelined, signed Q16.16.
// Accept to o_valid: S0, six lane dividers of one quotient bit per stage, P1, P2, output.
// Throughput: one item per cycle while the output is not stalled; P1 saturates to Q16.16.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; payload registers are not reset.
module ray_aabb_slab_test (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rast_pkg::t_ray_in i_in,
    output logic              o_valid,
    input  logic              i_stall,
    output rast_pkg::t_ray_out o_out
);
    import rast_pkg::*;

    localparam int W   = VALUE_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int QB  = W + F;
    localparam int NV  = QB + 4;   // S0, QB divider stages, P1, P2, output

    localparam logic [W-1:0]  LIM   = {1'b1, {(W-1){1'b0}}};
    localparam logic [QB-1:0] LIM_Q = {{F{1'b0}}, LIM};

    // sideband that rides along with the dividers
    typedef struct packed {
        logic [5:0] neg;   // quotient sign per lane
        logic [2:0] dz;    // direction component is zero
        logic [2:0] inb;   // origin within the slab
    } t_sb;

    // pipeline advance: everything moves unless the finished item is held
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    logic [NV-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NV-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[NV-1];

    // ---------------- S0: face distances, magnitudes, signs ----------------
    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];
    logic signed [W-1:0] blo [3];
    logic signed [W-1:0] bhi [3];
    always_comb begin
        org[0] = i_in.origin_x;  org[1] = i_in.origin_y;  org[2] = i_in.origin_z;
        dir[0] = i_in.dir_x;     dir[1] = i_in.dir_y;     dir[2] = i_in.dir_z;
        blo[0] = i_in.box_lo_x;  blo[1] = i_in.box_lo_y;  blo[2] = i_in.box_lo_z;
        bhi[0] = i_in.box_hi_x;  bhi[1] = i_in.box_hi_y;  bhi[2] = i_in.box_hi_z;
    end

    logic [W-1:0] n_a [6];
    logic [W-1:0] n_b [3];
    t_sb          n_sb;

    always_comb begin
        logic signed [W:0]   df;
        logic [W:0]          mg;
        logic                nneg;
        logic                dneg;
        logic signed [W-1:0] mn;
        logic signed [W-1:0] mx;
        logic [W:0]          dm;
        n_sb = '0;
        for (int j = 0; j < 3; j++) begin
            dneg   = dir[j][W-1];
            dm     = dneg ? -{dir[j][W-1], dir[j]} : {dir[j][W-1], dir[j]};
            n_b[j] = dm[W-1:0];
            n_sb.dz[j] = (dir[j] == '0);
            mn = (blo[j] < bhi[j]) ? blo[j] : bhi[j];
            mx = (blo[j] < bhi[j]) ? bhi[j] : blo[j];
            n_sb.inb[j] = (org[j] >= mn) && (org[j] <= mx);
            for (int s = 0; s < 2; s++) begin
                df   = (s == 0) ? ({blo[j][W-1], blo[j]} - {org[j][W-1], org[j]})
                                : ({bhi[j][W-1], bhi[j]} - {org[j][W-1], org[j]});
                nneg = df[W];
                mg   = nneg ? -df : df;
                n_a[2*j+s] = mg[W-1:0];
                n_sb.neg[2*j+s] = (nneg != dneg) && (mg != '0);
            end
        end
    end

    logic [W-1:0] r_a [6];
    logic [W-1:0] r_b [3];
    t_sb          r_sb [QB+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a      <= n_a;
            r_b      <= n_b;
            r_sb[0]  <= n_sb;
            for (int k = 1; k <= QB; k++) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // ---------------- divider lanes: lo and hi face per axis ----------------
    logic [QB-1:0] quo [6];
    for (genvar l = 0; l < 6; l++) begin : g_lane
        rast_div #(.W(W), .F(F)) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r_a[l]),
            .i_den (r_b[l/2]),
            .o_quo (quo[l])
        );
    end

    // ---------------- P1: saturate and apply sign ----------------
    function automatic logic [W-1:0] fx_conv(input logic [QB-1:0] q, input logic ng);
        logic [W-1:0] qs;
        qs = (q > LIM_Q) ? LIM : q[W-1:0];
        if (ng) begin
            return -qs;
        end
        return (qs > LIM - 1'b1) ? LIM - 1'b1 : qs;
    endfunction

    logic signed [W-1:0] r_t [6];
    logic [2:0]          r_dz1;
    logic [2:0]          r_inb1;
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                r_t[l] <= fx_conv(quo[l], r_sb[QB].neg[l]);
            end
            r_dz1  <= r_sb[QB].dz;
            r_inb1 <= r_sb[QB].inb;
        end
    end

    // ---------------- P2: order pairs, narrow interval ----------------
    logic signed [W-1:0] n_tmin, n_tmax;
    logic                n_ok;
    always_comb begin
        logic signed [W-1:0] t0;
        logic signed [W-1:0] t1;
        n_tmin = LIM;
        n_tmax = LIM - 1'b1;
        n_ok   = 1'b1;
        for (int j = 0; j < 3; j++) begin
            t0 = (r_t[2*j] > r_t[2*j+1]) ? r_t[2*j+1] : r_t[2*j];
            t1 = (r_t[2*j] > r_t[2*j+1]) ? r_t[2*j]   : r_t[2*j+1];
            if (r_dz1[j]) begin
                // zero direction: unbounded slab or certain miss
                if (!r_inb1[j]) n_ok = 1'b0;
            end else begin
                if (t0 > n_tmin) n_tmin = t0;
                if (t1 < n_tmax) n_tmax = t1;
            end
        end
    end

    logic signed [W-1:0] r_tmin, r_tmax;
    logic                r_ok;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tmin <= n_tmin;
            r_tmax <= n_tmax;
            r_ok   <= n_ok;
        end
    end

    // ---------------- output register ----------------
    t_ray_out r_out;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out.hit     <= r_ok && (r_tmin <= r_tmax);
            r_out.t_entry <= (r_ok && (r_tmin <= r_tmax)) ? r_tmin : '0;
        end
    end
    assign o_out = r_out;

endmodule

// ===== src/rast_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, (num << F) / den.
module rast_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [W-1:0]   i_num,
    input  logic [W-1:0]   i_den,
    output logic [W+F-1:0] o_quo
);
    localparam int QB = W + F;

    // stage k shifts its quotient bit into the low end of r_num[k]
    logic [W-1:0]  r_rem [QB-1];
    logic [QB-1:0] r_num [QB];
    logic [W-1:0]  r_den [QB-1];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [W-1:0]  rem_in;
        logic [QB-1:0] num_in;
        logic [W-1:0]  den_in;
        logic [W:0]    sh;
        logic          ge;
        if (k == 0) begin : g_src
            assign rem_in = '0;
            assign num_in = {i_num, {F{1'b0}}};
            assign den_in = i_den;
        end else begin : g_src
            assign rem_in = r_rem[k-1];
            assign num_in = r_num[k-1];
            assign den_in = r_den[k-1];
        end
        always_comb begin
            sh = {rem_in, num_in[QB-1]};
            ge = sh >= {1'b0, den_in};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= {num_in[QB-2:0], ge};
            end
        end
        // remainder and divisor only travel on to a following stage
        if (k < QB - 1) begin : g_keep
            logic [W:0] dif;
            assign dif = sh - {1'b0, den_in};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? dif[W-1:0] : sh[W-1:0];
                    r_den[k] <= den_in;
                end
            end
        end
    end

    assign o_quo = r_num[QB-1];

endmodule
